// ===== src/m4mul_pkg.sv =====
// Package for the 4x4 column-major matrix multiplier.
// Holds the transaction structs, controller/datapath command types and constants.
// No dependencies.
`default_nettype none

package m4mul_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int IDX_W     = 4;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam logic [IDX_W-1:0] LAST_CELL = 4'd15;

    typedef struct packed {
        logic [IDX_W-1:0]         elem_index;
        logic signed [ELEM_W-1:0] left_elem;
        logic signed [ELEM_W-1:0] right_elem;
        logic                     start_product;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [ELEM_W-1:0] out_value;
        logic                     saturated;
        logic                     last_cell;
    } out_t;

    typedef struct packed {
        logic             wr_en;
        logic             issue;
        logic [1:0]       k;
        logic [IDX_W-1:0] cell_idx;
        logic             load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/m4mul_ctrl.sv =====
// Controller for the matrix multiplier: sequences loads, MAC issue, drain and emit.
// Depends on m4mul_pkg.
`default_nettype none

module m4mul_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_start,
    output logic               in_ready,
    output m4mul_pkg::cmd_t    cmd,
    input  wire m4mul_pkg::sts_t sts
);
    import m4mul_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [1:0]       k_reg;
    logic [IDX_W-1:0] cell_reg;

    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.wr_en    = in_valid && (state_reg == ST_IDLE);
    assign cmd.issue    = (state_reg == ST_ISSUE);
    assign cmd.k        = k_reg;
    assign cmd.cell_idx = cell_reg;
    assign cmd.load_out = (state_reg == ST_EMIT) && sts.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            cell_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_start)
                    begin
                        state_reg <= ST_ISSUE;
                        k_reg     <= '0;
                        cell_reg  <= '0;
                    end
                end
                ST_ISSUE:
                begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    // product stage then accumulate stage
                    if (k_reg == 2'd1)
                    begin
                        state_reg <= ST_EMIT;
                        k_reg     <= '0;
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                ST_EMIT:
                begin
                    if (sts.out_free)
                    begin
                        k_reg <= '0;
                        if (cell_reg == LAST_CELL)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_ISSUE;
                            cell_reg  <= cell_reg + 4'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/m4mul_dp.sv =====
// Datapath for the matrix multiplier: matrix stores, multiplier, accumulator,
// shift/saturate and output register. Depends on m4mul_pkg.
`default_nettype none

module m4mul_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire m4mul_pkg::in_t  in_data,
    input  wire m4mul_pkg::cmd_t cmd,
    output m4mul_pkg::sts_t    sts,
    output logic               out_valid,
    input  wire logic          out_ready,
    output m4mul_pkg::out_t    out_data
);
    import m4mul_pkg::*;

    logic [ELEM_W-1:0] left_mem  [16];
    logic [ELEM_W-1:0] right_mem [16];

    logic [IDX_W-1:0] left_addr;
    logic [IDX_W-1:0] right_addr;

    logic signed [ELEM_W-1:0] rd_left_reg;
    logic signed [ELEM_W-1:0] rd_right_reg;
    logic                     v1_reg;
    logic                     first1_reg;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     v2_reg;
    logic                     first2_reg;

    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] shifted;
    logic                    fits;

    out_t out_next;
    out_t out_reg;
    logic out_valid_reg;

    // left cell (row, k) at 4k+row, right cell (k, col) at 4col+k
    assign left_addr  = {cmd.k, cmd.cell_idx[1:0]};
    assign right_addr = {cmd.cell_idx[3:2], cmd.k};

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            left_mem[in_data.elem_index]  <= in_data.left_elem;
            right_mem[in_data.elem_index] <= in_data.right_elem;
        end
        if (cmd.issue)
        begin
            rd_left_reg  <= left_mem[left_addr];
            rd_right_reg <= right_mem[right_addr];
        end
    end

    assign prod_next = rd_left_reg * rd_right_reg;
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_next  = first2_reg ? prod_ext : acc_reg + prod_ext;

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= prod_next;
        end
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            first1_reg <= 1'b0;
            v2_reg     <= 1'b0;
            first2_reg <= 1'b0;
        end
        else
        begin
            v1_reg     <= cmd.issue;
            first1_reg <= (cmd.k == 2'd0);
            v2_reg     <= v1_reg;
            first2_reg <= first1_reg;
        end
    end

    // arithmetic shift truncates toward minus infinity, then clip to 32 bits
    assign shifted = acc_reg >>> FRAC_BITS;
    assign fits    = (shifted[ACC_W-1:ELEM_W-1] == {(ACC_W-ELEM_W+1){shifted[ELEM_W-1]}});

    always_comb
    begin
        out_next.out_index = cmd.cell_idx;
        out_next.last_cell = (cmd.cell_idx == LAST_CELL);
        out_next.saturated = !fits;
        if (fits)
        begin
            out_next.out_value = shifted[ELEM_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            out_next.out_value = {1'b1, {(ELEM_W-1){1'b0}}};
        end
        else
        begin
            out_next.out_value = {1'b0, {(ELEM_W-1){1'b1}}};
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== src/matrix4_multiply_column_major.sv =====
// Top level of the 4x4 column-major Q16.16 matrix multiplier.
// Instantiates m4mul_ctrl and m4mul_dp; depends on m4mul_pkg.
//
// Each input transaction writes one cell of the left and right matrices at
// elem_index. A transaction with start_product set then computes the product
// and emits 16 result transactions in index order, the last one marked by
// last_cell; no input is taken until the sixteenth cell has been loaded into
// the output register. Every cell runs four multiply-accumulate steps through
// a single shared 32x32 multiplier with registered store reads. Sums are
// shifted right by 16 with truncation and saturated to 32 bits; saturated
// flags a clipped cell. Cells must be written before a product reads them.
`default_nettype none

module matrix4_multiply_column_major (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire m4mul_pkg::in_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output m4mul_pkg::out_t    out_data
);
    import m4mul_pkg::*;

    cmd_t cmd;
    sts_t sts;

    m4mul_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_start (in_data.start_product),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    m4mul_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
